### design/apl_pkg.sv
`default_nettype none
package apl_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 18;
  localparam int unsigned PeakW   = 24;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned MulW    = 25;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CntW    = 5;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [GainW-1:0]          gain_t;
  typedef logic [PeakW-1:0]          peak_t;
  typedef logic [CoefW-1:0]          coef_t;
  typedef logic [LevelW-1:0]         level_t;
  typedef logic [2:0]                reg_idx_t;

  // register map, byte address = 4 * index
  localparam reg_idx_t RegDecay   = 3'd0;
  localparam reg_idx_t RegRelease = 3'd1;
  localparam reg_idx_t RegLevel   = 3'd2;
  localparam reg_idx_t RegMinGain = 3'd3;
  localparam reg_idx_t RegMaxGain = 3'd4;

  localparam coef_t  DecayReset   = 24'd8387350;
  localparam coef_t  ReleaseReset = 24'd2349;
  localparam level_t LevelReset   = 15'd30000;
  localparam gain_t  MinGainReset = 18'd0;
  localparam gain_t  MaxGainReset = 18'd65536;

  localparam peak_t PeakReset = 24'd7680000;  // 30000.0 in Q16.8
  localparam gain_t GainReset = 18'd65536;    // 1.0 in Q2.16
  localparam peak_t PeakMax   = 24'hFFFFFF;
  localparam gain_t GainMax   = 18'h3FFFF;

  // quotient bits 17..0, one per cycle
  localparam logic [CntW-1:0] DivLast = 5'd17;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECAY,
    ST_PEAK,
    ST_DIVCHK,
    ST_DIV,
    ST_CLAMP,
    ST_REL_MUL,
    ST_REL_ADD,
    ST_OUT_MUL,
    ST_OUT_SAT,
    ST_RESULT
  } apl_state_e;

endpackage
`default_nettype wire

### design/apl_if.sv
`default_nettype none
interface apl_in_if;
  logic             valid;
  logic             ready;
  apl_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface apl_out_if;
  logic             valid;
  logic             ready;
  apl_pkg::sample_t sample_out;
  apl_pkg::gain_t   gain_now;

  modport source (output valid, output sample_out, output gain_now, input ready);
  modport sink   (input valid, input sample_out, input gain_now, output ready);
endinterface
`default_nettype wire

### design/audio_peak_limiter_top.sv
// Each accepted request runs decay, peak, a divide check, the 18-step restoring divider for
// target/peak, clamp, a release multiply and add when the gain recovers, then the output multiply
// and saturation; the divide is skipped when the target saturates, and a zero envelope goes straight
// to the result. The next request is taken only in idle; up to three shared 25x25 multiplies serve it.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, async): registers to their defaults, envelope 30000.0, gain 1.0.
`default_nettype none
module audio_peak_limiter_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  apl_in_if.sink                        in_i,
  apl_out_if.source                     out_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [apl_pkg::AddrW-1:0] paddr,
  input  wire logic [apl_pkg::DataW-1:0] pwdata,
  output logic      [apl_pkg::DataW-1:0] prdata,
  output logic                          pready
);

  // ---------------- configuration port ----------------
  apl_pkg::coef_t  decay_q, release_q;
  apl_pkg::level_t level_q;
  apl_pkg::gain_t  min_q, max_q;
  apl_pkg::reg_idx_t reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q   <= apl_pkg::DecayReset;
      release_q <= apl_pkg::ReleaseReset;
      level_q   <= apl_pkg::LevelReset;
      min_q     <= apl_pkg::MinGainReset;
      max_q     <= apl_pkg::MaxGainReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        apl_pkg::RegDecay:   decay_q   <= pwdata[apl_pkg::CoefW-1:0];
        apl_pkg::RegRelease: release_q <= pwdata[apl_pkg::CoefW-1:0];
        apl_pkg::RegLevel:   level_q   <= pwdata[apl_pkg::LevelW-1:0];
        apl_pkg::RegMinGain: min_q     <= pwdata[apl_pkg::GainW-1:0];
        apl_pkg::RegMaxGain: max_q     <= pwdata[apl_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      apl_pkg::RegDecay:   prdata = apl_pkg::DataW'(decay_q);
      apl_pkg::RegRelease: prdata = apl_pkg::DataW'(release_q);
      apl_pkg::RegLevel:   prdata = apl_pkg::DataW'(level_q);
      apl_pkg::RegMinGain: prdata = apl_pkg::DataW'(min_q);
      apl_pkg::RegMaxGain: prdata = apl_pkg::DataW'(max_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  apl_pkg::apl_state_e state_q, state_d;
  apl_pkg::peak_t      peak_q;
  apl_pkg::gain_t      gain_q;
  logic                out_valid_q;
  logic [apl_pkg::CntW-1:0] cnt_q;

  apl_pkg::sample_t         sample_q;
  logic signed [apl_pkg::ProdW-1:0] prod_q;
  logic [apl_pkg::PeakW-1:0] rem_q;
  apl_pkg::gain_t           quot_q;
  apl_pkg::gain_t           diff_q;
  apl_pkg::sample_t         y_q;
  apl_pkg::sample_t         out_sample_q;
  apl_pkg::gain_t           out_gain_q;

  // ---------------- shared multiplier ----------------
  logic signed [apl_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [apl_pkg::ProdW-1:0] mul_p;
  logic in_acc, res_load, out_acc;

  assign mul_p = mul_a * mul_b;

  // ---------------- datapath terms ----------------
  logic [apl_pkg::SampleW-1:0] sample_u, abs_s;
  apl_pkg::peak_t mag, dec_sat, peak_new;
  logic [apl_pkg::PeakW:0] decayed;
  logic ovf;
  logic [apl_pkg::PeakW:0] div_shift, div_sub;
  logic div_ge;
  apl_pkg::gain_t tgt_clamp;
  logic tgt_lower;
  logic [42:0] rel_rnd;
  logic [19:0] rel_step;
  logic [20:0] rel_sum;
  apl_pkg::gain_t gain_rel;
  logic signed [apl_pkg::ProdW-1:0] out_rnd;
  logic signed [33:0] out_y;
  apl_pkg::sample_t y_sat;

  assign sample_u = sample_q;
  assign abs_s    = sample_q[apl_pkg::SampleW-1] ? (~sample_u + 16'd1) : sample_u;
  assign mag      = {abs_s, 8'b0};
  assign decayed  = prod_q[47:23];
  assign dec_sat  = decayed[apl_pkg::PeakW] ? apl_pkg::PeakMax : decayed[apl_pkg::PeakW-1:0];
  assign peak_new = (mag > dec_sat) ? mag : dec_sat;

  // quotient overflows 18 bits when (level << 24) >= peak << 18
  assign ovf = {3'b0, level_q, 6'b0} >= peak_q;

  assign div_shift = {rem_q, 1'b0};
  assign div_ge    = div_shift >= {1'b0, peak_q};
  assign div_sub   = div_shift - {1'b0, peak_q};

  always_comb begin
    priority if (quot_q < min_q) tgt_clamp = min_q;
    else if (quot_q > max_q)     tgt_clamp = max_q;
    else                         tgt_clamp = quot_q;
  end
  assign tgt_lower = tgt_clamp < gain_q;

  assign rel_rnd  = prod_q[42:0] + 43'h400000;
  assign rel_step = rel_rnd[42:23];
  assign rel_sum  = 21'(gain_q) + 21'(rel_step);
  assign gain_rel = (|rel_sum[20:18]) ? apl_pkg::GainMax : rel_sum[17:0];

  assign out_rnd = prod_q + 50'sd32768;
  assign out_y   = out_rnd[49:16];
  always_comb begin
    priority if (out_y > 34'sd32767) y_sat = 16'sh7FFF;
    else if (out_y < -34'sd32768)    y_sat = 16'sh8000;
    else                             y_sat = out_y[15:0];
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apl_pkg::ST_IDLE:    if (in_acc) state_d = apl_pkg::ST_DECAY;
      apl_pkg::ST_DECAY:   state_d = apl_pkg::ST_PEAK;
      apl_pkg::ST_PEAK:    state_d = (peak_new == '0) ? apl_pkg::ST_RESULT
                                                      : apl_pkg::ST_DIVCHK;
      apl_pkg::ST_DIVCHK:  state_d = ovf ? apl_pkg::ST_CLAMP : apl_pkg::ST_DIV;
      apl_pkg::ST_DIV:     if (cnt_q == '0) state_d = apl_pkg::ST_CLAMP;
      apl_pkg::ST_CLAMP:   state_d = tgt_lower ? apl_pkg::ST_OUT_MUL : apl_pkg::ST_REL_MUL;
      apl_pkg::ST_REL_MUL: state_d = apl_pkg::ST_REL_ADD;
      apl_pkg::ST_REL_ADD: state_d = apl_pkg::ST_OUT_MUL;
      apl_pkg::ST_OUT_MUL: state_d = apl_pkg::ST_OUT_SAT;
      apl_pkg::ST_OUT_SAT: state_d = apl_pkg::ST_RESULT;
      apl_pkg::ST_RESULT:  if (res_load) state_d = apl_pkg::ST_IDLE;
      default:             state_d = apl_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    in_i.ready = (state_q == apl_pkg::ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      apl_pkg::ST_DECAY: begin
        mul_a = $signed({1'b0, peak_q});
        mul_b = $signed({1'b0, decay_q});
      end
      apl_pkg::ST_REL_MUL: begin
        mul_a = $signed({7'b0, diff_q});
        mul_b = $signed({1'b0, release_q});
      end
      apl_pkg::ST_OUT_MUL: begin
        mul_a = $signed({{9{sample_q[apl_pkg::SampleW-1]}}, sample_q});
        mul_b = $signed({7'b0, gain_q});
      end
      default: ;
    endcase
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign res_load = (state_q == apl_pkg::ST_RESULT) && (!out_valid_q || out_o.ready);

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.gain_now   = out_gain_q;

  // ---------------- control and limiter state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apl_pkg::ST_IDLE;
      peak_q      <= apl_pkg::PeakReset;
      gain_q      <= apl_pkg::GainReset;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        apl_pkg::ST_PEAK:    peak_q <= peak_new;
        apl_pkg::ST_DIVCHK:  cnt_q  <= apl_pkg::DivLast;
        apl_pkg::ST_DIV:     cnt_q  <= cnt_q - 5'd1;
        apl_pkg::ST_CLAMP:   if (tgt_lower) gain_q <= tgt_clamp;
        apl_pkg::ST_REL_ADD: gain_q <= gain_rel;
        default: ;
      endcase
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.sample_in;
    end
    unique case (state_q)
      apl_pkg::ST_DECAY, apl_pkg::ST_REL_MUL, apl_pkg::ST_OUT_MUL: prod_q <= mul_p;
      apl_pkg::ST_PEAK: if (peak_new == '0) y_q <= '0;
      apl_pkg::ST_DIVCHK: begin
        rem_q  <= {3'b0, level_q, 6'b0};
        quot_q <= ovf ? apl_pkg::GainMax : '0;
      end
      apl_pkg::ST_DIV: begin
        rem_q  <= div_ge ? div_sub[apl_pkg::PeakW-1:0] : div_shift[apl_pkg::PeakW-1:0];
        quot_q <= {quot_q[apl_pkg::GainW-2:0], div_ge};
      end
      apl_pkg::ST_CLAMP:   diff_q <= tgt_clamp - gain_q;
      apl_pkg::ST_OUT_SAT: y_q <= y_sat;
      default: ;
    endcase
    if (res_load) begin
      out_sample_q <= y_q;
      out_gain_q   <= gain_q;
    end
  end

  // ---------------- assertions ----------------
  // divider remainder must stay below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apl_pkg::ST_DIV) |-> (rem_q < peak_q))
    else $error("divider remainder not below envelope");

  // divide path is only entered with a nonzero envelope
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apl_pkg::ST_DIVCHK) |-> (peak_q != '0))
    else $error("divide started with zero envelope");

  // step counter in range while dividing
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apl_pkg::ST_DIV) |-> (cnt_q <= apl_pkg::DivLast))
    else $error("divider step count out of range");

  // a request moves the sequencer straight into the decay multiply
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == apl_pkg::ST_DECAY) && !in_i.ready)
    else $error("request accepted but sequencer did not start");

endmodule
`default_nettype wire
